// ===== design/cisi_pkg.sv =====
// constants, item codes and state encoding for the common id set intersection unit
// no dependencies
package cisi_pkg;
    localparam int MAX_IDS   = 4096;
    localparam int ADDR_W    = $clog2(MAX_IDS);
    localparam int ID_W      = 31;
    localparam int TOTAL_W   = 13;
    localparam int MATCH_W   = 16;
    localparam int KIND_W    = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_IDS);
    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;
endpackage

// ===== design/common_id_set_intersection_unit.sv =====
// common id set intersection unit: id store in one synchronous ram, scanned per query
// depends on cisi_pkg
// clear, load and unused kinds give their result beat in the cycle after acceptance
// a query scans the store one ram read per cycle and stops early when a match is found;
// one item is worked on at a time
// rate is set by the single read port of the id ram
// reset: synchronous active low, empties the store and zeroes both totals, no clearing pass
module common_id_set_intersection_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cisi_pkg::KIND_W-1:0]   i_kind,
    input  logic [cisi_pkg::ID_W-1:0]     i_atom_id,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cisi_pkg::ID_W-1:0]     o_echo_id,
    output logic                          o_is_common,
    output logic                          o_load_dropped,
    output logic [cisi_pkg::TOTAL_W-1:0]  o_stored_total,
    output logic [cisi_pkg::MATCH_W-1:0]  o_common_total
);
    import cisi_pkg::*;

    // id ram, contents meaningful only below the count
    logic [ID_W-1:0]    r_mem [MAX_IDS];
    logic [ID_W-1:0]    r_rdata;

    t_state             r_state, n_state;
    logic [TOTAL_W-1:0] r_count;
    logic [MATCH_W-1:0] r_match;
    logic [TOTAL_W-1:0] r_idx;     // next address to read
    logic               r_pend;    // read data valid this cycle
    logic [ID_W-1:0]    r_qid;     // query id being searched

    // output register
    logic               r_oval;
    logic [ID_W-1:0]    r_echo;
    logic               r_hit;
    logic               r_drop;

    logic accept, out_free, rd_en, cmp_hit, scan_done, full;

    assign out_free  = !r_oval || i_ready;
    assign o_ready   = (r_state == S_IDLE) && out_free;
    assign accept    = i_valid && o_ready;
    assign full      = (r_count >= TOTAL_MAX);
    assign rd_en     = (r_state == S_SCAN) && (r_idx < r_count);
    assign cmp_hit   = r_pend && (r_rdata == r_qid);
    // done on a match or once the last compare has been seen
    assign scan_done = (r_state == S_SCAN) && (cmp_hit || (r_idx == r_count));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_kind == KIND_QUERY) n_state = S_SCAN;
            S_SCAN: if (scan_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ram write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_LOAD && !full) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_atom_id;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_match <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (rd_en) r_idx <= r_idx + 1'b1;
            if (o_valid && i_ready) r_oval <= 1'b0;

            if (accept) begin
                case (i_kind)
                    KIND_CLEAR: begin
                        r_count <= '0;
                        r_match <= '0;
                        r_oval  <= 1'b1;
                    end
                    KIND_LOAD: begin
                        if (!full) r_count <= r_count + 1'b1;
                        r_oval <= 1'b1;
                    end
                    KIND_QUERY: begin
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                    end
                    default: r_oval <= 1'b1;
                endcase
            end

            if (scan_done) begin
                r_oval <= 1'b1;
                if (cmp_hit && r_match != MATCH_MAX) r_match <= r_match + 1'b1;
            end
        end
    end

    // payload of the result beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit  <= 1'b0;
            r_drop <= (i_kind == KIND_LOAD) && full;
            r_echo <= (i_kind == KIND_LOAD || i_kind == KIND_QUERY) ? i_atom_id : '0;
        end
        if (accept && i_kind == KIND_QUERY) r_qid <= i_atom_id;
        if (scan_done) r_hit <= cmp_hit;
    end

    assign o_valid        = r_oval;
    assign o_echo_id      = r_echo;
    assign o_is_common    = r_hit;
    assign o_load_dropped = r_drop;
    assign o_stored_total = r_count;
    assign o_common_total = r_match;

    // no result beat is presented while a search is running
    a_no_out_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_oval) else $error("result during scan");
    // count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TOTAL_MAX) else $error("count overflow");
    // scan index never runs past the count
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count)) else $error("scan overrun");
    // a finished search always delivers a beat
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |=> r_oval) else $error("lost query result");
endmodule
